[hw/rtl/jcs_pkg.sv]
// Shared types, scan mode codes and character constants for the JSON comment stripper.
package jcs_pkg;

  // Scan mode codes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_SLASH  = 3'd1;
  localparam logic [2:0] MODE_STRING = 3'd2;
  localparam logic [2:0] MODE_ESCAPE = 3'd3;
  localparam logic [2:0] MODE_LINE   = 3'd4;
  localparam logic [2:0] MODE_BLOCK  = 3'd5;
  localparam logic [2:0] MODE_STAR   = 3'd6;

  // Characters the scanner looks for
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last_run;
    logic       done;
  } jcs_res_t;

  // Everything one input item produces: up to two results in order
  typedef struct packed {
    logic [1:0] cnt;
    jcs_res_t   r0;
    jcs_res_t   r1;
  } jcs_scan_t;

endpackage

[hw/rtl/json_comment_stripper.sv]
// Top level of the JSON comment stripper: scanner and output buffer.
//
// Input channel (in_valid / in_stall): one byte of JSON text per item, with
// text_end high on the last byte of a text. Output channel (out_valid /
// out_stall): cleaned bytes; has_byte is low on a bare end marker,
// last_of_run marks the last result of an input item and stream_done the
// final result of a text. Comments are dropped, strings pass untouched.
// Timing: the first result of an item is registered and shown in the cycle after
// it is accepted; a second result (a held slash followed by a plain byte) waits
// in the pending slot until the output register is free. Throughput: one item
// per cycle while out_stall is low and each item gives at most one result; an
// item with two results stalls input while the single output register drains it.
// Reset: scan mode returns to normal text and the output is emptied.
// While the receiver stalls, the output holds and in_stall rises as soon as
// the output register and pending slot cannot take another item.
module json_comment_stripper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       text_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       last_of_run,
  output logic       stream_done
);

  jcs_pkg::jcs_scan_t scan;
  logic               ready;
  logic               pend_valid;
  logic               accept;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  jcs_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .in_byte  (in_byte),
    .text_end (text_end),
    .scan     (scan)
  );

  jcs_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .scan        (scan),
    .ready       (ready),
    .pend_valid  (pend_valid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .last_of_run (last_of_run),
    .stream_done (stream_done)
  );

`ifndef SYNTHESIS
  // A pending second result always sits behind a shown result
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("pending result without output result");

  // No item is taken while a second result waits
  a_pend_blocks_in: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> in_stall)
    else $error("input accepted while result pending");

  // A text end always yields a result in the next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && text_end) |=> out_valid)
    else $error("text end gave no result");

  // The final result of a text closes its item's run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_done) |-> last_of_run)
    else $error("stream done on a result that is not last of run");
`endif

endmodule

[hw/rtl/jcs_scan.sv]
// Scan mode register and per-byte decode into zero, one or two result items.
module jcs_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          in_byte,
  input  logic                text_end,
  output jcs_pkg::jcs_scan_t  scan
);

  logic [2:0] mode;
  logic [2:0] mode_next;

  // Plain-text handling of the byte, used in normal mode and after a lone slash
  logic       nb_emit;
  logic [2:0] nb_mode;

  // Bytes to emit before the end marker logic
  logic [1:0] emit_cnt;
  logic [7:0] a0;
  logic [7:0] a1;
  logic [1:0] cnt;

  always_comb begin
    if (in_byte == jcs_pkg::CH_QUOTE) begin
      nb_emit = 1'b1;
      nb_mode = jcs_pkg::MODE_STRING;
    end else if (in_byte == jcs_pkg::CH_SLASH && !text_end) begin
      nb_emit = 1'b0;
      nb_mode = jcs_pkg::MODE_SLASH;
    end else begin
      nb_emit = 1'b1;
      nb_mode = jcs_pkg::MODE_NORMAL;
    end
  end

  // Decode the byte against the current mode
  always_comb begin
    emit_cnt  = 2'd0;
    a0        = in_byte;
    a1        = in_byte;
    mode_next = mode;
    case (mode)
      jcs_pkg::MODE_SLASH: begin
        if (in_byte == jcs_pkg::CH_SLASH) begin
          mode_next = jcs_pkg::MODE_LINE;
        end else if (in_byte == jcs_pkg::CH_STAR) begin
          mode_next = jcs_pkg::MODE_BLOCK;
        end else begin
          a0        = jcs_pkg::CH_SLASH;
          emit_cnt  = nb_emit ? 2'd2 : 2'd1;
          mode_next = nb_mode;
        end
      end
      jcs_pkg::MODE_STRING: begin
        emit_cnt = 2'd1;
        if (in_byte == jcs_pkg::CH_BACKSLASH) begin
          mode_next = jcs_pkg::MODE_ESCAPE;
        end else if (in_byte == jcs_pkg::CH_QUOTE) begin
          mode_next = jcs_pkg::MODE_NORMAL;
        end
      end
      jcs_pkg::MODE_ESCAPE: begin
        emit_cnt  = 2'd1;
        mode_next = jcs_pkg::MODE_STRING;
      end
      jcs_pkg::MODE_LINE: begin
        if (in_byte == jcs_pkg::CH_LF || in_byte == jcs_pkg::CH_CR) begin
          emit_cnt  = 2'd1;
          mode_next = jcs_pkg::MODE_NORMAL;
        end
      end
      jcs_pkg::MODE_BLOCK: begin
        if (in_byte == jcs_pkg::CH_STAR) begin
          mode_next = jcs_pkg::MODE_STAR;
        end
      end
      jcs_pkg::MODE_STAR: begin
        if (in_byte == jcs_pkg::CH_SLASH) begin
          mode_next = jcs_pkg::MODE_NORMAL;
        end else if (in_byte != jcs_pkg::CH_STAR) begin
          mode_next = jcs_pkg::MODE_BLOCK;
        end
      end
      default: begin
        emit_cnt  = nb_emit ? 2'd1 : 2'd0;
        mode_next = nb_mode;
      end
    endcase
    // Return to normal text after the end of a text
    if (text_end) begin
      mode_next = jcs_pkg::MODE_NORMAL;
    end
  end

  // Build result items; a text end with nothing to emit gives a bare marker
  always_comb begin
    cnt = emit_cnt;
    if (text_end && emit_cnt == 2'd0) begin
      cnt = 2'd1;
    end
    scan.cnt         = cnt;
    scan.r0.data     = (emit_cnt == 2'd0) ? 8'd0 : a0;
    scan.r0.has      = (emit_cnt != 2'd0);
    scan.r0.last_run = (cnt == 2'd1);
    scan.r0.done     = (cnt == 2'd1) && text_end;
    scan.r1.data     = a1;
    scan.r1.has      = 1'b1;
    scan.r1.last_run = 1'b1;
    scan.r1.done     = text_end;
  end

  // Advance the mode on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jcs_pkg::MODE_NORMAL;
    end else if (advance) begin
      mode <= mode_next;
    end
  end

endmodule

[hw/rtl/jcs_outbuf.sv]
// Output register with one pending slot for the second result of an item.
module jcs_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  jcs_pkg::jcs_scan_t  scan,
  output logic                ready,
  output logic                pend_valid,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic                last_of_run,
  output logic                stream_done
);

  jcs_pkg::jcs_res_t out_res;
  jcs_pkg::jcs_res_t pend_res;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;
  assign ready    = out_free && !pend_valid;

  // Control: drain the pending slot first, then take fresh results
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (load && scan.cnt != 2'd0) begin
        out_valid  <= 1'b1;
        pend_valid <= (scan.cnt == 2'd2);
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_res <= pend_res;
      end else if (load) begin
        out_res  <= scan.r0;
        pend_res <= scan.r1;
      end
    end
  end

  assign out_byte    = out_res.data;
  assign has_byte    = out_res.has;
  assign last_of_run = out_res.last_run;
  assign stream_done = out_res.done;

endmodule
